// File: hdl/tfzg_pkg.sv
// ----------------------------------------------------------------------------
// tfzg_pkg
// Types, codes and constants shared by the three-finger zoom detector.
// ----------------------------------------------------------------------------
package tfzg_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int NUM_SLOTS      = 3;
    localparam int POS_W          = 16;
    localparam int THR_W          = 16;
    localparam int CNT_W          = 4;
    localparam int IN_TDATA_W     = 40;
    localparam int IN_TUSER_W     = 3;
    localparam int OUT_TDATA_W    = 8;

    localparam logic [THR_W-1:0] ZOOM_THRESHOLD_RESET = 16'd240;
    localparam logic [CNT_W-1:0] FINGER_MAX           = 4'd15;
    localparam logic [CNT_W-1:0] FINGER_START         = 4'd3;

    typedef enum logic [2:0] {
        MODE_DOWN   = 3'd0,
        MODE_MOTION = 3'd1,
        MODE_UP     = 3'd2,
        MODE_FRAME  = 3'd3,
        MODE_CANCEL = 3'd4
    } mode_t;

    typedef enum logic [2:0] {
        STAT_IGNORE    = 3'd0,
        STAT_BEGIN     = 3'd1,
        STAT_UPDATE    = 3'd2,
        STAT_FINISHED  = 3'd3,
        STAT_CANCELLED = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_IN   = 2'd1,
        DIR_OUT  = 2'd2
    } dir_t;

    typedef struct packed {
        logic [POS_W-1:0] pos_y;
        logic [POS_W-1:0] pos_x;
        logic [1:0]       slot;
        mode_t            mode;
    } item_t;

    typedef struct packed {
        dir_t    overall_direction;
        dir_t    recent_direction;
        status_t gesture_status;
    } result_t;

endpackage

// File: hdl/tfzg_in_reg.sv
// ----------------------------------------------------------------------------
// tfzg_in_reg
// Input register: captures one touch event per transfer.
// ----------------------------------------------------------------------------
module tfzg_in_reg
    import tfzg_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  s_valid,
    output logic  s_ready,
    input  item_t s_item,
    input  logic  advance,
    output logic  valid,
    output item_t item
);

    logic  valid_reg;
    item_t item_reg;

    // take a new event when empty or when the held one moves on this cycle
    assign s_ready = !valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_ready)
        begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_ready && s_valid)
        begin
            item_reg <= s_item;
        end
    end

    assign valid = valid_reg;
    assign item  = item_reg;

endmodule

// File: hdl/tfzg_core.sv
// ----------------------------------------------------------------------------
// tfzg_core
// Gesture state and per-event update: finger count, flags, three point sets
// and the spread comparison that decides zoom direction.
// ----------------------------------------------------------------------------
module tfzg_core
    import tfzg_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [THR_W-1:0] cfg_wdata,
    input  logic             fire,
    input  item_t            item,
    output result_t          result
);

    // wide enough for a signed difference of two doubled spreads and 2*threshold
    localparam int DW = (COORD_BITS + 3 > THR_W + 2) ? COORD_BITS + 3 : THR_W + 2;

    logic [THR_W-1:0]      thr_reg;
    logic [CNT_W-1:0]      cnt_reg, cnt_next, cnt_inc, cnt_dec;
    logic                  started_reg, started_a, started_next;
    logic                  canc_reg, canc_a, canc_next;
    dir_t                  dir_reg, dir_a, dir_next;
    logic [COORD_BITS-1:0] sx_reg [NUM_SLOTS];
    logic [COORD_BITS-1:0] sy_reg [NUM_SLOTS];
    logic [COORD_BITS-1:0] lx_reg [NUM_SLOTS];
    logic [COORD_BITS-1:0] ly_reg [NUM_SLOTS];
    logic [COORD_BITS-1:0] cx_reg [NUM_SLOTS];
    logic [COORD_BITS-1:0] cy_reg [NUM_SLOTS];
    logic [COORD_BITS-1:0] sx_a [NUM_SLOTS];
    logic [COORD_BITS-1:0] sy_a [NUM_SLOTS];
    logic [COORD_BITS-1:0] lx_a [NUM_SLOTS];
    logic [COORD_BITS-1:0] ly_a [NUM_SLOTS];
    logic [COORD_BITS-1:0] cx_a [NUM_SLOTS];
    logic [COORD_BITS-1:0] cy_a [NUM_SLOTS];
    logic [COORD_BITS-1:0] sx_next [NUM_SLOTS];
    logic [COORD_BITS-1:0] sy_next [NUM_SLOTS];
    logic [COORD_BITS-1:0] lx_next [NUM_SLOTS];
    logic [COORD_BITS-1:0] ly_next [NUM_SLOTS];
    logic [COORD_BITS-1:0] cx_next [NUM_SLOTS];
    logic [COORD_BITS-1:0] cy_next [NUM_SLOTS];
    logic [COORD_BITS-1:0] px, py;
    logic signed [DW-1:0]  thr2, d_frame, d_frame_abs, d_all;
    status_t               status;
    dir_t                  odir;
    logic                  clear_now, finish_clear;

    function automatic logic signed [DW-1:0] abs_s(input logic signed [DW-1:0] v);
        return (v < 0) ? -v : v;
    endfunction

    // doubled Manhattan distance from slot 1 to the midpoint of slots 0 and 2
    function automatic logic signed [DW-1:0] spread(
        input logic [COORD_BITS-1:0] x0, x1, x2, y0, y1, y2
    );
        logic signed [DW-1:0] dx, dy;
        dx = $signed(DW'(x0) + DW'(x2) - (DW'(x1) << 1));
        dy = $signed(DW'(y0) + DW'(y2) - (DW'(y1) << 1));
        return abs_s(dx) + abs_s(dy);
    endfunction

    assign px   = COORD_BITS'(item.pos_x);
    assign py   = COORD_BITS'(item.pos_y);
    assign thr2 = $signed(DW'({thr_reg, 1'b0}));

    assign cnt_inc = (cnt_reg == FINGER_MAX) ? cnt_reg : cnt_reg + CNT_W'(1);
    assign cnt_dec = (cnt_reg == '0) ? cnt_reg : cnt_reg - CNT_W'(1);

    assign d_frame = spread(cx_reg[0], cx_reg[1], cx_reg[2], cy_reg[0], cy_reg[1], cy_reg[2])
                   - spread(lx_reg[0], lx_reg[1], lx_reg[2], ly_reg[0], ly_reg[1], ly_reg[2]);
    assign d_frame_abs = abs_s(d_frame);

    // state after the event, before the deferred clear of the finished path
    always_comb
    begin
        cnt_next     = cnt_reg;
        started_a    = started_reg;
        canc_a       = canc_reg;
        dir_a        = dir_reg;
        sx_a         = sx_reg;
        sy_a         = sy_reg;
        lx_a         = lx_reg;
        ly_a         = ly_reg;
        cx_a         = cx_reg;
        cy_a         = cy_reg;
        status       = STAT_IGNORE;
        clear_now    = 1'b0;
        finish_clear = 1'b0;

        unique case (item.mode)
            MODE_DOWN:
            begin
                cnt_next = cnt_inc;
                if (!canc_reg)
                begin
                    for (int i = 0; i < NUM_SLOTS; i++)
                    begin
                        if (cnt_inc <= FINGER_START && item.slot == 2'(i))
                        begin
                            sx_a[i] = px;
                            sy_a[i] = py;
                        end
                    end
                    if (cnt_inc == FINGER_START)
                    begin
                        started_a = 1'b1;
                        lx_a      = sx_a;
                        ly_a      = sy_a;
                        cx_a      = sx_a;
                        cy_a      = sy_a;
                        status    = STAT_BEGIN;
                    end
                    else if (cnt_inc > FINGER_START)
                    begin
                        canc_a = 1'b1;
                        status = STAT_CANCELLED;
                    end
                end
            end
            MODE_MOTION:
            begin
                if (!canc_reg && started_reg)
                begin
                    for (int i = 0; i < NUM_SLOTS; i++)
                    begin
                        if (item.slot == 2'(i))
                        begin
                            cx_a[i] = px;
                            cy_a[i] = py;
                        end
                    end
                end
            end
            MODE_UP:
            begin
                cnt_next = cnt_dec;
                if (cnt_dec == '0)
                begin
                    if (!canc_reg && started_reg && dir_reg != DIR_NONE)
                    begin
                        status       = STAT_FINISHED;
                        finish_clear = 1'b1;
                    end
                    else
                    begin
                        clear_now = 1'b1;
                    end
                end
            end
            MODE_FRAME:
            begin
                if (!canc_reg && started_reg && d_frame_abs >= thr2)
                begin
                    lx_a   = cx_reg;
                    ly_a   = cy_reg;
                    dir_a  = (d_frame > 0) ? DIR_IN : DIR_OUT;
                    status = STAT_UPDATE;
                end
            end
            MODE_CANCEL:
            begin
                canc_a = 1'b1;
                status = STAT_CANCELLED;
            end
            default:
            begin
            end
        endcase

        if (clear_now)
        begin
            started_a = 1'b0;
            canc_a    = 1'b0;
            dir_a     = DIR_NONE;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                sx_a[i] = '0;
                sy_a[i] = '0;
                lx_a[i] = '0;
                ly_a[i] = '0;
                cx_a[i] = '0;
                cy_a[i] = '0;
            end
        end
    end

    assign d_all = spread(cx_a[0], cx_a[1], cx_a[2], cy_a[0], cy_a[1], cy_a[2])
                 - spread(sx_a[0], sx_a[1], sx_a[2], sy_a[0], sy_a[1], sy_a[2]);

    always_comb
    begin
        priority if (d_all > thr2)
        begin
            odir = DIR_IN;
        end
        else if (d_all < -thr2)
        begin
            odir = DIR_OUT;
        end
        else
        begin
            odir = DIR_NONE;
        end
    end

    assign result.gesture_status    = status;
    assign result.recent_direction  = dir_a;
    assign result.overall_direction = odir;

    // the finished path reports first, then drops the gesture
    always_comb
    begin
        started_next = finish_clear ? 1'b0 : started_a;
        canc_next    = finish_clear ? 1'b0 : canc_a;
        dir_next     = finish_clear ? DIR_NONE : dir_a;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            sx_next[i] = finish_clear ? '0 : sx_a[i];
            sy_next[i] = finish_clear ? '0 : sy_a[i];
            lx_next[i] = finish_clear ? '0 : lx_a[i];
            ly_next[i] = finish_clear ? '0 : ly_a[i];
            cx_next[i] = finish_clear ? '0 : cx_a[i];
            cy_next[i] = finish_clear ? '0 : cy_a[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= ZOOM_THRESHOLD_RESET;
        end
        else if (cfg_we)
        begin
            thr_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            started_reg <= 1'b0;
            canc_reg    <= 1'b0;
            dir_reg     <= DIR_NONE;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                sx_reg[i] <= '0;
                sy_reg[i] <= '0;
                lx_reg[i] <= '0;
                ly_reg[i] <= '0;
                cx_reg[i] <= '0;
                cy_reg[i] <= '0;
            end
        end
        else if (fire)
        begin
            cnt_reg     <= cnt_next;
            started_reg <= started_next;
            canc_reg    <= canc_next;
            dir_reg     <= dir_next;
            sx_reg      <= sx_next;
            sy_reg      <= sy_next;
            lx_reg      <= lx_next;
            ly_reg      <= ly_next;
            cx_reg      <= cx_next;
            cy_reg      <= cy_next;
        end
    end

    a_started_has_fingers: assert property (@(posedge clk) disable iff (!rst_n)
        started_reg |-> cnt_reg != '0)
        else $error("gesture started with no fingers down");

    a_dir_needs_start: assert property (@(posedge clk) disable iff (!rst_n)
        dir_reg != DIR_NONE |-> started_reg)
        else $error("zoom direction held outside a started gesture");

    a_cancel_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.mode == MODE_CANCEL |=> canc_reg)
        else $error("cancel event did not set the cancelled flag");

endmodule

// File: hdl/tfzg_out_reg.sv
// ----------------------------------------------------------------------------
// tfzg_out_reg
// Result register on the master side; holds a result until it is taken.
// ----------------------------------------------------------------------------
module tfzg_out_reg
    import tfzg_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t result,
    output logic    can_load,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_result
);

    logic    valid_reg;
    result_t result_reg;

    assign can_load = !valid_reg || m_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (can_load)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    assign m_valid  = valid_reg;
    assign m_result = result_reg;

endmodule

// File: hdl/three_finger_zoom_gesture_detector.sv
// ----------------------------------------------------------------------------
// three_finger_zoom_gesture_detector
// Tracks three touch fingers and reports zoom gesture status per event.
// ----------------------------------------------------------------------------
//  channel   dir  signals                         payload
//  s_axis    in   tvalid tready tdata tuser       touch event
//  m_axis    out  tvalid tready tdata             gesture status
//  cfg       in   cfg_we cfg_wdata                zoom_threshold
//
//  An event goes from transfer to result through the input register, then
//  the state update and spread compare into the result register.
//  One event per cycle without master stalls; the result register frees the input.
//  Reset clears the gesture state and loads a threshold of 240.
//  A stalled master side holds the result and, once both registers are
//  full, drops s_axis_tready.
// ----------------------------------------------------------------------------
module three_finger_zoom_gesture_detector
    import tfzg_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [THR_W-1:0]       cfg_wdata,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [1:0] slot, [17:2] pos_x, [33:18] pos_y, [39:34] zero
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // [2:0] mode
    input  logic [IN_TUSER_W-1:0]  s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [2:0] gesture_status, [4:3] recent_direction, [6:5] overall_direction, [7] zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    item_t   s_item, item;
    result_t result, m_result;
    logic    in_valid, can_load, advance;

    assign s_item.mode  = mode_t'(s_axis_tuser);
    assign s_item.slot  = s_axis_tdata[1:0];
    assign s_item.pos_x = s_axis_tdata[17:2];
    assign s_item.pos_y = s_axis_tdata[33:18];

    assign advance = in_valid && can_load;

    tfzg_in_reg u_in_reg (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .s_item  (s_item),
        .advance (advance),
        .valid   (in_valid),
        .item    (item)
    );

    tfzg_core #(
        .COORD_BITS (COORD_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .fire      (advance),
        .item      (item),
        .result    (result)
    );

    tfzg_out_reg u_out_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (advance),
        .result   (result),
        .can_load (can_load),
        .m_valid  (m_axis_tvalid),
        .m_ready  (m_axis_tready),
        .m_result (m_result)
    );

    assign m_axis_tdata = {1'b0, m_result};

endmodule

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the three-finger zoom gesture detector. Touch events
// go in over the slave stream and an event-level predictor forms the status
// expected for each transfer. The bench covers directed corner cases,
// threshold extremes, finger-count saturation and long runs of random
// gestures. Both stream sides idle at random, and the threshold is rewritten
// between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import tfzg_pkg::*;

    localparam int          TOTAL_EVENTS = 1250;
    localparam int          PIPE_LATENCY = 2;
    localparam int          IDLE_MAX     = 17;
    localparam int          CFG_PERIOD   = 150;
    localparam int          TIMEOUT_NS   = 5_000_000;
    localparam logic [1:0]  SLOT_INVALID = 2'd3;
    localparam logic [2:0]  MODE_LAST    = 3'd7;

    typedef logic [NUM_SLOTS-1:0][1:0][POS_W-1:0] pts_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [THR_W-1:0]       cfg_wdata;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic [IN_TUSER_W-1:0]  s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    // predictor state
    logic [CNT_W-1:0]       fingers;
    bit                     started;
    bit                     cancelled;
    dir_t                   dir_last;
    pts_t                   pt_start;
    pts_t                   pt_last;
    pts_t                   pt_cur;
    logic [THR_W-1:0]       thr;

    result_t                pending_status[$];
    int                     events_sent;
    int                     mismatches;
    int                     thr_writes;
    int                     status_seen[8];
    int                     tx_idle_max;
    int                     rx_idle_max;

    three_finger_zoom_gesture_detector u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("tb NOT OK");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Doubled Manhattan distance from slot 1 to the midpoint of slots 0 and 2
    function automatic longint pinch_spread(input pts_t p);
        longint dx;
        longint dy;
        dx = longint'(p[0][0]) + longint'(p[2][0]) - 2 * longint'(p[1][0]);
        dy = longint'(p[0][1]) + longint'(p[2][1]) - 2 * longint'(p[1][1]);
        return (dx < 0 ? -dx : dx) + (dy < 0 ? -dy : dy);
    endfunction

    function automatic void clear_gesture();
        started   = 1'b0;
        cancelled = 1'b0;
        dir_last  = DIR_NONE;
        pt_start  = '0;
        pt_last   = '0;
        pt_cur    = '0;
    endfunction

    function automatic result_t track_touch_event(input logic [2:0] m, input logic [1:0] s,
                                                  input logic [POS_W-1:0] x,
                                                  input logic [POS_W-1:0] y);
        result_t r;
        bit      finish_clear;
        longint  d;
        longint  t;
        r            = '0;
        r.gesture_status = STAT_IGNORE;
        finish_clear = 1'b0;
        case (m)
            MODE_DOWN:
            begin
                if (fingers != FINGER_MAX)
                    fingers = fingers + 1'b1;
                if (!cancelled)
                begin
                    if (fingers <= FINGER_START && s < NUM_SLOTS)
                    begin
                        pt_start[s][0] = x;
                        pt_start[s][1] = y;
                    end
                    if (fingers == FINGER_START)
                    begin
                        started          = 1'b1;
                        pt_last          = pt_start;
                        pt_cur           = pt_start;
                        r.gesture_status = STAT_BEGIN;
                    end
                    else if (fingers > FINGER_START)
                    begin
                        cancelled        = 1'b1;
                        r.gesture_status = STAT_CANCELLED;
                    end
                end
            end
            MODE_MOTION:
            begin
                if (!cancelled && started && s < NUM_SLOTS)
                begin
                    pt_cur[s][0] = x;
                    pt_cur[s][1] = y;
                end
            end
            MODE_UP:
            begin
                if (fingers != 0)
                    fingers = fingers - 1'b1;
                if (fingers == 0)
                begin
                    if (!cancelled && started && dir_last != DIR_NONE)
                    begin
                        r.gesture_status = STAT_FINISHED;
                        finish_clear     = 1'b1;
                    end
                    else
                        clear_gesture();
                end
            end
            MODE_FRAME:
            begin
                if (!cancelled && started)
                begin
                    d = pinch_spread(pt_cur) - pinch_spread(pt_last);
                    if ((d < 0 ? -d : d) >= 2 * longint'(thr))
                    begin
                        pt_last          = pt_cur;
                        dir_last         = (d > 0) ? DIR_IN : DIR_OUT;
                        r.gesture_status = STAT_UPDATE;
                    end
                end
            end
            MODE_CANCEL:
            begin
                cancelled        = 1'b1;
                r.gesture_status = STAT_CANCELLED;
            end
            default:
            begin
            end
        endcase

        // directions come from the state after the event, before a finish clear
        r.recent_direction = dir_last;
        d = pinch_spread(pt_cur) - pinch_spread(pt_start);
        t = 2 * longint'(thr);
        if (d > t)
            r.overall_direction = DIR_IN;
        else if (d < -t)
            r.overall_direction = DIR_OUT;
        else
            r.overall_direction = DIR_NONE;
        if (finish_clear)
            clear_gesture();
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stream drivers
    // ------------------------------------------------------------------------

    task automatic send_event(input logic [2:0] m, input logic [1:0] s,
                              input logic [POS_W-1:0] x, input logic [POS_W-1:0] y);
        int gap;
        gap = $urandom_range(0, tx_idle_max);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_TDATA_W - 2 * POS_W - 2){1'b0}}, y, x, s};
        s_axis_tuser  <= m;
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_status.push_back(track_touch_event(m, s, x, y));
        events_sent++;
    endtask

    // Drop valid and hold until every status has come back
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_status.size() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 2) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [THR_W-1:0] value);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        thr       = value;
        thr_writes++;
    endtask

    // Result side: random stall before each transfer, then check it
    initial
    begin
        int      stall;
        result_t got;
        result_t want;
        m_axis_tready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = $urandom_range(0, rx_idle_max);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
            got = result_t'(m_axis_tdata[6:0]);
            if (pending_status.size() == 0)
            begin
                if (mismatches < 10)
                    $display("%0t: unexpected status transfer, tdata=%h", $realtime,
                             m_axis_tdata);
                mismatches++;
            end
            else
            begin
                want = pending_status.pop_front();
                status_seen[want.gesture_status]++;
                if (got.gesture_status !== want.gesture_status
                    || got.recent_direction !== want.recent_direction
                    || got.overall_direction !== want.overall_direction
                    || m_axis_tdata[7] !== 1'b0)
                begin
                    if (mismatches < 10)
                        $display("%0t: status exp %0d/%0d/%0d got %0d/%0d/%0d pad %b",
                                 $realtime, want.gesture_status, want.recent_direction,
                                 want.overall_direction, got.gesture_status,
                                 got.recent_direction, got.overall_direction,
                                 m_axis_tdata[7]);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    task automatic test_directed();
        // outer fingers at the origin, middle finger at the far corner
        send_event(MODE_DOWN, 2'd0, 16'h0000, 16'h0000);
        send_event(MODE_DOWN, 2'd1, 16'hFFFF, 16'hFFFF);
        send_event(MODE_DOWN, 2'd2, 16'h0000, 16'h0000);
        send_event(MODE_MOTION, 2'd1, 16'h0000, 16'h0000);
        send_event(MODE_FRAME, 2'd0, 16'h0000, 16'h0000);
        send_event(MODE_MOTION, 2'd0, 16'hFFFF, 16'hFFFF);
        send_event(MODE_FRAME, 2'd0, 16'h0000, 16'h0000);
        // unchanged spread stays below threshold
        send_event(MODE_FRAME, 2'd0, 16'h0000, 16'h0000);
        // out-of-range slot writes no point
        send_event(MODE_MOTION, SLOT_INVALID, 16'h0001, 16'h0001);
        send_event(MODE_UP, 2'd0, 16'h0000, 16'h0000);
        send_event(MODE_UP, 2'd1, 16'h0000, 16'h0000);
        send_event(MODE_UP, 2'd2, 16'h0000, 16'h0000);
        // lift with no finger down saturates at zero
        send_event(MODE_UP, 2'd0, 16'hFFFF, 16'hFFFF);
        send_event(MODE_CANCEL, 2'd0, 16'h0000, 16'h0000);
        send_event(MODE_UP, 2'd0, 16'h0000, 16'h0000);
        // fourth finger cancels
        send_event(MODE_DOWN, 2'd0, 16'h1234, 16'hABCD);
        send_event(MODE_DOWN, 2'd1, 16'h5555, 16'hAAAA);
        send_event(MODE_DOWN, 2'd2, 16'hAAAA, 16'h5555);
        send_event(MODE_DOWN, SLOT_INVALID, 16'hFFFF, 16'h0000);
        repeat (4) send_event(MODE_UP, 2'd0, 16'h0000, 16'h0000);
        for (int m = MODE_CANCEL + 1; m <= MODE_LAST; m++)
            send_event(3'(m), 2'd1, 16'hFFFF, 16'hFFFF);
    endtask

    task automatic test_threshold_extremes();
        // zero threshold: an unchanged spread still counts as zoom out
        write_threshold('0);
        send_event(MODE_DOWN, 2'd0, 16'($urandom), 16'($urandom));
        send_event(MODE_DOWN, 2'd1, 16'($urandom), 16'($urandom));
        send_event(MODE_DOWN, 2'd2, 16'($urandom), 16'($urandom));
        send_event(MODE_FRAME, 2'd0, 16'h0000, 16'h0000);
        repeat (3) send_event(MODE_UP, 2'd0, 16'h0000, 16'h0000);
        // full threshold: only the widest swing qualifies
        write_threshold('1);
        send_event(MODE_DOWN, 2'd0, 16'h0000, 16'h0000);
        send_event(MODE_DOWN, 2'd1, 16'hFFFF, 16'hFFFF);
        send_event(MODE_DOWN, 2'd2, 16'h0000, 16'h0000);
        send_event(MODE_MOTION, 2'd1, 16'h8000, 16'h8000);
        send_event(MODE_FRAME, 2'd0, 16'h0000, 16'h0000);
        send_event(MODE_MOTION, 2'd1, 16'h0000, 16'h0000);
        send_event(MODE_FRAME, 2'd0, 16'h0000, 16'h0000);
        repeat (3) send_event(MODE_UP, 2'd0, 16'h0000, 16'h0000);
    endtask

    task automatic test_finger_saturation();
        write_threshold(ZOOM_THRESHOLD_RESET);
        for (int k = 0; k < 17; k++)
            send_event(MODE_DOWN, 2'(k), 16'($urandom), 16'($urandom));
        repeat (17) send_event(MODE_UP, 2'($urandom_range(0, 3)), 16'($urandom),
                               16'($urandom));
    endtask

    task automatic send_noise();
        logic [2:0] m;
        repeat ($urandom_range(1, 8))
        begin
            if ($urandom_range(0, 9) < 8)
                m = 3'($urandom_range(MODE_DOWN, MODE_CANCEL));
            else
                m = 3'($urandom_range(MODE_CANCEL + 1, MODE_LAST));
            send_event(m, 2'($urandom_range(0, 3)), 16'($urandom), 16'($urandom));
        end
    endtask

    task automatic run_gesture();
        logic [POS_W-1:0] px[NUM_SLOTS];
        logic [POS_W-1:0] py[NUM_SLOTS];
        logic [1:0]       s;
        int               first;
        // lift leftovers so the gesture starts from no fingers
        while (fingers != 0)
            send_event(MODE_UP, 2'($urandom_range(0, 3)), 16'($urandom), 16'($urandom));
        for (int k = 0; k < NUM_SLOTS; k++)
        begin
            px[k] = 16'($urandom);
            py[k] = 16'($urandom);
        end
        first = $urandom_range(0, NUM_SLOTS - 1);
        for (int k = 0; k < NUM_SLOTS; k++)
        begin
            s = 2'((first + k) % NUM_SLOTS);
            if ($urandom_range(0, 15) == 0)
                s = 2'($urandom_range(0, 3));
            if (s < NUM_SLOTS)
                send_event(MODE_DOWN, s, px[s], py[s]);
            else
                send_event(MODE_DOWN, s, 16'($urandom), 16'($urandom));
        end
        repeat ($urandom_range(2, 14))
        begin
            case ($urandom_range(0, 19))
                0: send_event(MODE_CANCEL, 2'($urandom_range(0, 3)), 16'($urandom),
                              16'($urandom));
                1: send_event(MODE_DOWN, 2'($urandom_range(0, 3)), 16'($urandom),
                              16'($urandom));
                2, 3, 4, 5, 6, 7, 8, 9:
                begin
                    s = 2'($urandom_range(0, NUM_SLOTS - 1));
                    // mix fresh positions with small drifts around the last one
                    if ($urandom_range(0, 1))
                    begin
                        px[s] = 16'($urandom);
                        py[s] = 16'($urandom);
                    end
                    else
                    begin
                        px[s] = px[s] + 16'($urandom_range(0, 1023)) - 16'd512;
                        py[s] = py[s] + 16'($urandom_range(0, 1023)) - 16'd512;
                    end
                    send_event(MODE_MOTION, s, px[s], py[s]);
                end
                default: send_event(MODE_FRAME, 2'($urandom_range(0, 3)), 16'($urandom),
                                    16'($urandom));
            endcase
        end
        while (fingers != 0)
            send_event(MODE_UP, 2'($urandom_range(0, 3)), 16'($urandom), 16'($urandom));
    endtask

    task automatic test_random_traffic();
        int phase;
        int next_cfg;
        phase    = 0;
        next_cfg = events_sent;
        while (events_sent < TOTAL_EVENTS)
        begin
            if (events_sent >= next_cfg)
            begin
                case (phase % 6)
                    0: write_threshold(16'($urandom_range(0, 63)));
                    1: write_threshold('0);
                    2: write_threshold(16'($urandom_range(0, 4095)));
                    3: write_threshold(ZOOM_THRESHOLD_RESET);
                    4: write_threshold(16'($urandom));
                    default: write_threshold('1);
                endcase
                phase++;
                next_cfg = events_sent + CFG_PERIOD;
            end
            case ($urandom_range(0, 3))
                0:
                begin
                    tx_idle_max = 0;
                    rx_idle_max = 0;
                end
                1:
                begin
                    tx_idle_max = 0;
                    rx_idle_max = IDLE_MAX;
                end
                2:
                begin
                    tx_idle_max = IDLE_MAX;
                    rx_idle_max = 0;
                end
                default:
                begin
                    tx_idle_max = IDLE_MAX;
                    rx_idle_max = IDLE_MAX;
                end
            endcase
            if ($urandom_range(0, 4) == 0)
                send_noise();
            else
                run_gesture();
        end
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_wdata     <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        events_sent   = 0;
        mismatches    = 0;
        thr_writes    = 0;
        tx_idle_max   = IDLE_MAX;
        rx_idle_max   = IDLE_MAX;
        foreach (status_seen[i])
            status_seen[i] = 0;
        fingers = '0;
        thr     = ZOOM_THRESHOLD_RESET;
        clear_gesture();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_threshold_extremes();
        test_finger_saturation();
        test_random_traffic();
        wait_idle();

        $display("Sent %0d touch events over %0d threshold writes.", events_sent, thr_writes);
        $display("Statuses: %0d ignore, %0d begin, %0d update, %0d finished, %0d cancelled.",
                 status_seen[STAT_IGNORE], status_seen[STAT_BEGIN],
                 status_seen[STAT_UPDATE], status_seen[STAT_FINISHED],
                 status_seen[STAT_CANCELLED]);
        if (mismatches == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
